[hw/rtl/ipv6_route_table_lpm_assert.svh]
// Assertion macros for the IPv6 route table checker.
// Used by ipv6_route_table_lpm_chk.sv; no other dependencies.
`ifndef IPV6_ROUTE_TABLE_LPM_ASSERT_SVH
`define IPV6_ROUTE_TABLE_LPM_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define RT_ASSERT_IMP(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("rt check failed");

// Next-cycle implication outside reset.
`define RT_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("rt check failed");

`endif

[hw/rtl/rtl_pkg.sv]
// Package for the IPv6 route table: types, command codes, mask function.
// No dependencies.
package rtl_pkg;

  localparam int unsigned TableDepthDef = 64;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SCAN,
    ST_WRITE,
    ST_FETCH,
    ST_FETCH2,
    ST_REPLY
  } state_e;

  // One table row as stored in memory.
  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  len;
    logic [63:0] nh_hi;
    logic [63:0] nh_lo;
    logic [7:0]  if_idx;
    logic [7:0]  rtype;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;   // latch the input item
    logic scan_clr;  // restart scan bookkeeping
    logic scan_en;   // evaluate the row read last cycle
    logic wr_en;     // write current item into target slot
    logic inv_en;    // clear the valid bit of the found slot
    logic fetch;     // read the best row
    logic res_load;  // build the result
  } ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] cmd;
    logic found;
    logic free_ok;
  } sts_t;

  // Prefix mask for a 128-bit address; lengths above 128 saturate.
  function automatic logic [127:0] prefix_mask(input logic [7:0] len);
    logic [127:0] m;
    m = '1;
    if (len == 8'd0) begin
      m = '0;
    end else if (len < 8'd128) begin
      m = ~('1 >> len);
    end
    return m;
  endfunction

endpackage

[hw/rtl/rtl_ram.sv]
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module rtl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hw/rtl/rtl_ctrl.sv]
// Controller state machine for the IPv6 route table.
// Depends on rtl_pkg.
module rtl_ctrl import rtl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic res_busy_i,
  input  sts_t sts_i,
  input  logic scan_last_i,
  output ctl_t ctl_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i && !res_busy_i) state_d = ST_PRIME;
      ST_PRIME:  state_d = ST_SCAN;
      ST_SCAN: begin
        if (scan_last_i) begin
          if (sts_i.cmd == CMD_LOOKUP) state_d = ST_FETCH;
          else if (sts_i.cmd == CMD_INSERT || sts_i.cmd == CMD_DELETE) state_d = ST_WRITE;
          else state_d = ST_REPLY;
        end
      end
      ST_WRITE:  state_d = ST_REPLY;
      ST_FETCH:  state_d = ST_FETCH2;
      ST_FETCH2: state_d = ST_REPLY;
      ST_REPLY:  state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = !res_busy_i;
        ctl_o.capture = in_valid_i && !res_busy_i;
        ctl_o.scan_clr = 1'b1;
      end
      ST_SCAN:  ctl_o.scan_en = 1'b1;
      ST_WRITE: begin
        ctl_o.wr_en  = (sts_i.cmd == CMD_INSERT) && (sts_i.found || sts_i.free_ok);
        ctl_o.inv_en = (sts_i.cmd == CMD_DELETE) && sts_i.found;
      end
      // hold the best row address so the reply sees that row
      ST_FETCH:  ctl_o.fetch = 1'b1;
      ST_FETCH2: ctl_o.fetch = 1'b1;
      ST_REPLY:  ctl_o.res_load = 1'b1;
      default: ;
    endcase
  end
endmodule

[hw/rtl/rtl_dpath.sv]
// Datapath for the IPv6 route table: item register, scan, table RAM, result.
// Depends on rtl_pkg and rtl_ram.
module rtl_dpath import rtl_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ctl_t          ctl_i,
  input  logic [1:0]    cmd_i,
  input  entry_t        item_i,
  output sts_t          sts_o,
  output logic          scan_last_o,
  output logic          res_busy_o,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output logic [145:0]  res_o
);
  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CW = $clog2(TableDepth + 1);

  logic [1:0]      cmd_q;
  entry_t          item_q;
  logic [TableDepth-1:0] valid_q;
  logic [CW-1:0]   rcnt_q, rcnt_d;
  logic [CW-1:0]   ecnt_q;
  logic            found_q, free_ok_q, best_ok_q;
  logic [AW-1:0]   found_idx_q, free_idx_q, best_idx_q;
  logic [7:0]      best_len_q;
  logic            rv_q;
  logic [AW-1:0]   raddr, waddr, eidx;
  entry_t          rdata;
  logic            wr_ram;
  logic [127:0]    mask, qaddr;
  logic            key_eq, pfx_eq;
  logic            res_valid_q;
  logic [145:0]    res_q, res_d;

  assign eidx = ecnt_q[AW-1:0];
  assign raddr = ctl_i.fetch ? best_idx_q : rcnt_q[AW-1:0];
  assign waddr = found_q ? found_idx_q : free_idx_q;
  assign wr_ram = ctl_i.wr_en;

  rtl_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_ram),
    .waddr_i(waddr),
    .wdata_i(item_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Compare logic on the row read last cycle
  assign mask   = prefix_mask(rdata.len);
  assign qaddr  = {item_q.addr_hi, item_q.addr_lo};
  assign key_eq = rdata.addr_hi == item_q.addr_hi && rdata.addr_lo == item_q.addr_lo &&
                  rdata.len == item_q.len;
  assign pfx_eq = {rdata.addr_hi, rdata.addr_lo} == (qaddr & mask);

  // Read counter runs one ahead of the evaluated row
  always_comb begin
    rcnt_d = rcnt_q;
    if (ctl_i.scan_clr) rcnt_d = '0;
    else if (rcnt_q != CW'(TableDepth)) rcnt_d = rcnt_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q  <= cmd_i;
      item_q <= item_i;
    end
  end

  // Scan bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rcnt_q <= '0;
      ecnt_q <= '0;
      rv_q <= 1'b0;
      found_q <= 1'b0;
      free_ok_q <= 1'b0;
      best_ok_q <= 1'b0;
      found_idx_q <= '0;
      free_idx_q <= '0;
      best_idx_q <= '0;
      best_len_q <= '0;
    end else begin
      rcnt_q <= rcnt_d;
      rv_q <= !ctl_i.scan_clr && rcnt_q != CW'(TableDepth);
      if (ctl_i.scan_clr) begin
        ecnt_q <= '0;
        found_q <= 1'b0;
        free_ok_q <= 1'b0;
        best_ok_q <= 1'b0;
        best_len_q <= '0;
      end else if (ctl_i.scan_en && rv_q) begin
        ecnt_q <= ecnt_q + 1'b1;
        if (valid_q[eidx]) begin
          if (!found_q && key_eq) begin
            found_q <= 1'b1;
            found_idx_q <= eidx;
          end
          if ((!best_ok_q || rdata.len > best_len_q) && pfx_eq) begin
            best_ok_q <= 1'b1;
            best_idx_q <= eidx;
            best_len_q <= rdata.len;
          end
        end else if (!free_ok_q) begin
          free_ok_q <= 1'b1;
          free_idx_q <= eidx;
        end
      end
      if (ctl_i.wr_en) valid_q[waddr] <= 1'b1;
      if (ctl_i.inv_en) valid_q[found_idx_q] <= 1'b0;
    end
  end

  assign scan_last_o = ctl_i.scan_en && rv_q && ecnt_q == CW'(TableDepth - 1);
  assign sts_o = '{cmd: cmd_q, found: found_q, free_ok: free_ok_q};

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (ctl_i.res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  // Result word: hit, full flag, then the best row's route fields
  always_comb begin
    res_d = '0;
    case (cmd_q)
      CMD_INSERT: begin
        res_d[0] = found_q;
        res_d[1] = !found_q && !free_ok_q;
      end
      CMD_DELETE: res_d[0] = found_q;
      CMD_LOOKUP: begin
        if (best_ok_q) res_d = {rdata.rtype, rdata.if_idx, rdata.nh_lo, rdata.nh_hi,
                                1'b0, 1'b1};
      end
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_load) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o = res_q;
  assign res_busy_o = res_valid_q && !res_ready_i;
endmodule

[hw/rtl/ipv6_route_table_lpm.sv]
// Channel  | Signals                      | Item
// s_axis   | tvalid tready tdata tuser    | command with route or query
// m_axis   | tvalid tready tdata tuser    | hit, full flag, route data
// Each command: accept, prime, a one-row-per-cycle scan of TableDepth rows (the
// single RAM read port sets the pace), then a write (insert, delete), a fetch of
// the best row in ST_FETCH and ST_FETCH2 (lookup) or nothing (nop), then reply.
// The next command is accepted only after the last one has replied. Reset
// clears all valid bits at once.
// A new item is taken once the result register is free or being drained.
// Top level; depends on rtl_pkg, rtl_ctrl, rtl_dpath, rtl_ram.
module ipv6_route_table_lpm import rtl_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // addr_hi[63:0] addr_lo[127:64] prefix_len[135:128] nexthop_in_hi[199:136]
  // nexthop_in_lo[263:200] iface_in[271:264] rtag_in[279:272]
  input  logic [279:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // nexthop_out_hi[63:0] nexthop_out_lo[127:64] iface_out[135:128] rtag_out[143:136]
  output logic [143:0] m_axis_tdata,
  // hit[0] table_full[1]
  output logic [1:0]   m_axis_tuser
);
  ctl_t   ctl;
  sts_t   sts;
  logic   scan_last, res_busy;
  entry_t item;
  logic [145:0] res;

  assign item = '{addr_hi: s_axis_tdata[63:0], addr_lo: s_axis_tdata[127:64],
                  len: s_axis_tdata[135:128], nh_hi: s_axis_tdata[199:136],
                  nh_lo: s_axis_tdata[263:200], if_idx: s_axis_tdata[271:264],
                  rtype: s_axis_tdata[279:272]};

  rtl_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .res_busy_i(res_busy), .sts_i(sts), .scan_last_i(scan_last), .ctl_o(ctl)
  );

  rtl_dpath #(.TableDepth(TableDepth)) u_dpath (
    .clk_i, .rst_ni, .ctl_i(ctl), .cmd_i(s_axis_tuser), .item_i(item),
    .sts_o(sts), .scan_last_o(scan_last), .res_busy_o(res_busy),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tuser = res[1:0];
  assign m_axis_tdata = res[145:2];
endmodule

[hw/rtl/ipv6_route_table_lpm_chk.sv]
// Port-level checker for the IPv6 route table, bound to the top level.
// Depends on ipv6_route_table_lpm_assert.svh.
`include "ipv6_route_table_lpm_assert.svh"
module ipv6_route_table_lpm_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [143:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);
  logic in_acc, full_res;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign full_res = m_axis_tvalid && m_axis_tuser[1];

  `RT_ASSERT_IMP(a_full_only_miss, clk_i, rst_ni, full_res, !m_axis_tuser[0])
  `RT_ASSERT_IMP(a_full_zero_data, clk_i, rst_ni, full_res, m_axis_tdata == '0)
  `RT_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_acc, !s_axis_tready)
  `RT_ASSERT_NXT(a_no_instant_result, clk_i, rst_ni, in_acc, !m_axis_tvalid)
endmodule

bind ipv6_route_table_lpm ipv6_route_table_lpm_chk u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tuser
);

[bench/testbench.sv]
// Self-checking bench for the IPv6 longest-prefix-match route table.
// Depends on rtl_pkg and ipv6_route_table_lpm; predicts each result in place.
module testbench;
  import rtl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 64;

  typedef struct packed {
    logic [7:0]  rtype;
    logic [7:0]  if_idx;
    logic [63:0] nh_lo;
    logic [63:0] nh_hi;
    logic [7:0]  len;
    logic [63:0] addr_lo;
    logic [63:0] addr_hi;
    logic [1:0]  cmd;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0]  rtype;
    logic [7:0]  if_idx;
    logic [63:0] nh_lo;
    logic [63:0] nh_hi;
    logic        full;
    logic        hit;
  } route_res_t;

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid, s_axis_tready;
  // addr_hi, addr_lo, prefix_len, nexthop_in_hi/lo, iface_in, rtag_in
  logic [279:0] s_axis_tdata;
  // cmd
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid, m_axis_tready;
  // nexthop_out_hi/lo, iface_out, rtag_out
  logic [143:0] m_axis_tdata;
  // hit, table_full
  logic [1:0]   m_axis_tuser;

  ipv6_route_table_lpm u_dut (.*);

  // Shadow route table
  logic        tbl_valid [Depth];
  logic [63:0] tbl_hi [Depth], tbl_lo [Depth], tbl_nh_hi [Depth], tbl_nh_lo [Depth];
  logic [7:0]  tbl_len [Depth], tbl_if [Depth], tbl_rt [Depth];

  route_res_t  pending_routes[$];
  int          err_count;
  bit          sink_stall_on;

  // A few learned prefixes, reused so lookups and deletes hit
  cmd_item_t   known_routes[$];

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic logic [127:0] len_mask(input logic [7:0] len);
    logic [127:0] m;
    if (len == 0) m = '0;
    else if (len >= 128) m = '1;
    else m = ~({128{1'b1}} >> len);
    return m;
  endfunction

  // Compute the result of one command and update the shadow table
  function automatic route_res_t route_predict(input cmd_item_t c);
    route_res_t r;
    int found, free_slot, best;
    logic [7:0] best_len;
    logic [127:0] m;
    r = '0; found = -1; free_slot = -1; best = -1; best_len = '0;
    if (c.cmd == CMD_INSERT || c.cmd == CMD_DELETE) begin
      for (int i = 0; i < Depth; i++) begin
        if (tbl_valid[i]) begin
          if (found < 0 && tbl_hi[i] == c.addr_hi && tbl_lo[i] == c.addr_lo &&
              tbl_len[i] == c.len) found = i;
        end else if (free_slot < 0) free_slot = i;
      end
      if (c.cmd == CMD_DELETE) begin
        if (found >= 0) begin
          tbl_valid[found] = 1'b0;
          r.hit = 1'b1;
        end
        return r;
      end
      if (found >= 0) r.hit = 1'b1;
      else if (free_slot >= 0) found = free_slot;
      else begin
        r.full = 1'b1;
        return r;
      end
      tbl_valid[found] = 1'b1; tbl_hi[found] = c.addr_hi; tbl_lo[found] = c.addr_lo;
      tbl_len[found] = c.len; tbl_nh_hi[found] = c.nh_hi; tbl_nh_lo[found] = c.nh_lo;
      tbl_if[found] = c.if_idx; tbl_rt[found] = c.rtype;
    end else if (c.cmd == CMD_LOOKUP) begin
      for (int i = 0; i < Depth; i++) begin
        if (!tbl_valid[i]) continue;
        if (best >= 0 && tbl_len[i] <= best_len) continue;
        m = len_mask(tbl_len[i]);
        if ({tbl_hi[i], tbl_lo[i]} == ({c.addr_hi, c.addr_lo} & m)) begin
          best = i;
          best_len = tbl_len[i];
        end
      end
      if (best >= 0) begin
        r.hit = 1'b1; r.nh_hi = tbl_nh_hi[best]; r.nh_lo = tbl_nh_lo[best];
        r.if_idx = tbl_if[best]; r.rtype = tbl_rt[best];
      end
    end
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 90);
  endfunction

  // Send one command item and queue its expected result; valid drops only in a gap
  task automatic send_cmd(input cmd_item_t c);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tdata  <= c[281:2];
    s_axis_tuser  <= c.cmd;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_routes.insert(pending_routes.size(), route_predict(c));
  endtask

  // Result checker with random back-pressure while sink_stall_on is set
  initial begin
    route_res_t got, want;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata, m_axis_tuser};
        if (pending_routes.size() == 0) begin
          report_mismatch("unexpected item", 64'(got.hit), 64'd0);
        end else begin
          want = pending_routes.pop_front();
          if (got.hit !== want.hit) report_mismatch("hit", 64'(got.hit), 64'(want.hit));
          if (got.full !== want.full)
            report_mismatch("table_full", 64'(got.full), 64'(want.full));
          if (got.nh_hi !== want.nh_hi) report_mismatch("nexthop_hi", got.nh_hi, want.nh_hi);
          if (got.nh_lo !== want.nh_lo) report_mismatch("nexthop_lo", got.nh_lo, want.nh_lo);
          if (got.if_idx !== want.if_idx)
            report_mismatch("ifidx", 64'(got.if_idx), 64'(want.if_idx));
          if (got.rtype !== want.rtype)
            report_mismatch("rtype", 64'(got.rtype), 64'(want.rtype));
        end
      end
      m_axis_tready <= sink_stall_on ? ($urandom_range(0, 99) < 60) : 1'b1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic cmd_item_t rand_route(input logic [7:0] len);
    cmd_item_t c;
    logic [127:0] a;
    c.cmd = CMD_INSERT;
    a = {rand64(), rand64()} & len_mask(len);
    {c.addr_hi, c.addr_lo} = a;
    c.len = len; c.nh_hi = rand64(); c.nh_lo = rand64();
    c.if_idx = 8'($urandom()); c.rtype = 8'($urandom());
    return c;
  endfunction

  // Query that falls inside a route: random host bits under its prefix
  function automatic cmd_item_t query_in(input cmd_item_t r);
    cmd_item_t q;
    logic [127:0] m;
    q = rand_route(8'd0);
    m = len_mask(r.len);
    {q.addr_hi, q.addr_lo} = ({r.addr_hi, r.addr_lo} & m) | ({rand64(), rand64()} & ~m);
    q.cmd = CMD_LOOKUP;
    return q;
  endfunction

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk_i);
  endtask

  // Directed: extreme lengths, nesting, unmasked keys, overwrite, delete, nop
  task automatic test_directed();
    cmd_item_t c, q;
    c = rand_route(8'd0); c.addr_hi = '0; c.addr_lo = '0;
    c.nh_hi = '1; c.nh_lo = '1; c.if_idx = 8'hff; c.rtype = 8'hff;
    send_cmd(c);                                   // default route
    q = query_in(c); send_cmd(q);
    c = rand_route(8'd128); send_cmd(c); send_cmd(query_in(c));
    c.nh_lo = '0; send_cmd(c);                     // overwrite same key
    send_cmd(query_in(c));
    q = rand_route(8'd200); send_cmd(q); send_cmd(query_in(q)); // length past 128
    q = rand_route(8'd64); send_cmd(q); send_cmd(query_in(q));
    q = rand_route(8'd65); send_cmd(q); send_cmd(query_in(q));
    c = rand_route(8'd16); c.addr_lo = 64'h1; send_cmd(c);   // host bits set
    q = c; q.cmd = CMD_LOOKUP; send_cmd(q);
    c.cmd = CMD_DELETE; send_cmd(c); send_cmd(c);            // then delete miss
    c.cmd = CMD_NOP; c.addr_hi = '1; c.addr_lo = '1; send_cmd(c);
    c = rand_route(8'd0); c.cmd = CMD_LOOKUP; c.addr_hi = '1; c.addr_lo = '1;
    send_cmd(c);
  endtask

  // Fill beyond capacity so inserts drop, then delete the routes it added
  task automatic test_table_full();
    cmd_item_t c;
    for (int i = 0; i < Depth + 4; i++) begin
      c = rand_route(8'($urandom_range(1, 128)));
      send_cmd(c);
      known_routes.insert(known_routes.size(), c);
    end
    while (known_routes.size() != 0) begin
      c = known_routes.pop_front();
      c.cmd = CMD_DELETE;
      send_cmd(c);
    end
  endtask

  // Random mix built on a small set of nested prefixes
  task automatic test_random(input int n);
    cmd_item_t c, base;
    int p;
    logic [319:0] raw;
    base = rand_route(8'd32);
    for (int i = 0; i < n; i++) begin
      if (i % 300 == 0) sink_stall_on = !sink_stall_on;
      p = $urandom_range(0, 99);
      if (known_routes.size() > 0 && p < 45) begin
        c = query_in(known_routes[$urandom_range(0, known_routes.size() - 1)]);
      end else if (p < 70 || known_routes.size() == 0) begin
        c = rand_route(8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) :
                          $urandom_range(8, 128)));
        if ($urandom_range(0, 1)) begin
          c.addr_hi = base.addr_hi;
          if (c.len > 32) c.addr_hi[63:32] = base.addr_hi[63:32];
          {c.addr_hi, c.addr_lo} = {c.addr_hi, c.addr_lo} & len_mask(c.len);
        end
        if (known_routes.size() < 80) known_routes.insert(known_routes.size(), c);
      end else if (p < 85) begin
        c = known_routes[$urandom_range(0, known_routes.size() - 1)];
        c.cmd = CMD_DELETE;
      end else if (p < 95) begin
        raw = {rand64(), rand64(), rand64(), rand64(), rand64()};
        c = raw[281:0];
        c.cmd = 2'($urandom_range(0, 3));
      end else begin
        c = known_routes[$urandom_range(0, known_routes.size() - 1)];
        c.nh_hi = rand64();                       // update in place
      end
      send_cmd(c);
    end
  endtask

  initial begin
    err_count = 0;
    sink_stall_on = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    for (int i = 0; i < Depth; i++) tbl_valid[i] = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_random(1550);
    wait_drain();
    repeat (200) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/rtl_pkg.sv
hw/rtl/rtl_ram.sv
hw/rtl/rtl_ctrl.sv
hw/rtl/rtl_dpath.sv
hw/rtl/ipv6_route_table_lpm.sv
hw/rtl/ipv6_route_table_lpm_chk.sv
bench/testbench.sv
